// ===== rtl/core/length_prefixed_deframer_assert.svh =====
// Assertion macros for the deframer RTL.
// No dependencies; included by files that check their own logic.
`ifndef LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lpd_pkg.sv =====
// Types and constants of the length-prefixed deframer.
// No dependencies; imported by lpd_update and length_prefixed_deframer.
package lpd_pkg;

   localparam int NUM_CONNS    = 1024;
   localparam int CONN_ADDR_W  = (NUM_CONNS > 1) ? $clog2(NUM_CONNS) : 1;
   localparam int CONN_EXT_W   = 17;
   localparam int CONN_W       = 10;
   localparam int BYTE_W       = 8;
   localparam int LEN_W        = 16;
   localparam int HDR_CNT_W    = 3;
   localparam logic [HDR_CNT_W-1:0] HDR_BYTES = 3'd4;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd10240;

   localparam logic CMD_OPEN = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_MAX_LEN = 1'b0;

   typedef enum logic [1:0] {
      KIND_BODY  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // Per-connection state word. Only the low 16 length bits are kept;
   // the upper two header bytes matter only as "nonzero" (always oversize).
   typedef struct packed {
      logic                 dropped;
      logic [HDR_CNT_W-1:0] hdr_cnt;
      logic [LEN_W-1:0]     len;
      logic                 len_hi_nz;
      logic [LEN_W-1:0]     body_cnt;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic     last;
   } res_type;

endpackage

// ===== rtl/core/lpd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; read-first when both ports hit the same entry.
module lpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lpd_update.sv =====
// Next-state and result logic for one connection's state word.
// Depends on lpd_pkg.
module lpd_update
   import lpd_pkg::*;
(
   input  logic              cmd,
   input  logic [BYTE_W-1:0] data_byte,
   input  entry_type         cur,
   input  logic [LEN_W-1:0]  max_len,
   output entry_type         nxt,
   output res_type           res
);

   logic [1:0]       pos;
   logic [LEN_W-1:0] body_inc;
   entry_type        hdr;

   always_comb begin
      pos      = cur.hdr_cnt[1:0];
      body_inc = cur.body_cnt + 1'b1;
      hdr      = cur;
      nxt      = cur;
      res      = '{valid: 1'b0, kind: KIND_BODY, last: 1'b0};

      // assemble the little-endian header
      case (pos)
         2'd0: hdr.len[7:0]  = data_byte;
         2'd1: hdr.len[15:8] = data_byte;
         2'd2: hdr.len_hi_nz = cur.len_hi_nz | (data_byte != '0);
         2'd3: hdr.len_hi_nz = cur.len_hi_nz | (data_byte != '0);
         default: hdr = cur;
      endcase
      hdr.hdr_cnt  = HDR_CNT_W'(pos) + 1'b1;
      hdr.body_cnt = '0;

      if (cmd == CMD_OPEN) begin
         nxt = '0;
      end else if (cur.dropped) begin
         nxt = cur;
      end else if (cur.hdr_cnt < HDR_BYTES) begin
         nxt = hdr;
         if (pos == 2'd3) begin
            if (hdr.len_hi_nz || (hdr.len > max_len)) begin
               nxt.dropped = 1'b1;
               res = '{valid: 1'b1, kind: KIND_ERROR, last: 1'b0};
            end else if (hdr.len == '0) begin
               nxt = '0;
               res = '{valid: 1'b1, kind: KIND_EMPTY, last: 1'b1};
            end
         end
      end else begin
         if (body_inc >= cur.len) begin
            nxt = '0;
            res = '{valid: 1'b1, kind: KIND_BODY, last: 1'b1};
         end else begin
            nxt.body_cnt = body_inc;
            res = '{valid: 1'b1, kind: KIND_BODY, last: 1'b0};
         end
      end
   end

endmodule

// ===== rtl/core/length_prefixed_deframer.sv =====
// Length-prefixed deframer: the per-connection framing state lives in a RAM.
// Depends on lpd_pkg, lpd_ram, lpd_update and length_prefixed_deframer_assert.svh.
//
// Usage:
//   req_* carries one request per accepted beat: tuser is the command (open or
//   data byte), tdata holds the connection number and the byte. rsp_* carries
//   zero or one result per request: tuser is the kind (body byte, empty
//   packet, length error), tlast marks the end of a packet, tdata holds the
//   connection and the body byte. csr_* is an APB port with one register,
//   max_packet_len, at byte address 0.
//   Outside the clearing sweep and while the receiver does not stall, throughput
//   is one request per cycle, set by the single read port and the single write port
//   of the state RAM; a request to the same connection taken as the previous one
//   advances is served by forwarding the just-written state word. The RAM read
//   registers when a request is taken, the update and the result when it advances.
//   After reset the block sweeps the state RAM to zero, one connection per
//   cycle, over all NUM_CONNS (1024) entries; req_tready stays low meanwhile, while
//   configuration writes are taken as usual.
//   When the receiver stalls, the result register holds, the update stage
//   holds behind it and req_tready drops; nothing is lost or repeated.
module length_prefixed_deframer
   import lpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // [9:0] conn_id, [17:10] data_byte, zero pad
   input  logic                  req_tuser,   // [0] cmd
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [9:0] out_conn, [17:10] out_byte, zero pad
   output logic [1:0]            rsp_tuser,   // [1:0] kind
   output logic                  rsp_tlast,   // packet_last
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

`include "length_prefixed_deframer_assert.svh"

   // ---------------- configuration ----------------
   logic [LEN_W-1:0] max_len_ff, max_len_in;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_wr && (csr_paddr[2] == CSR_IDX_MAX_LEN)) begin
         max_len_in = csr_pwdata[LEN_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MAX_LEN) ? {16'b0, max_len_ff} : 32'b0;

   // ---------------- request decode ----------------
   logic [CONN_W-1:0]      req_conn;
   logic [BYTE_W-1:0]      req_byte;
   logic [CONN_EXT_W-1:0]  req_conn_ext;
   logic [CONN_ADDR_W-1:0] req_addr;
   logic                   req_acc;

   assign req_conn     = req_tdata[9:0];
   assign req_byte     = req_tdata[17:10];
   assign req_conn_ext = CONN_EXT_W'(req_conn);
   assign req_addr     = req_conn_ext[CONN_ADDR_W-1:0];
   assign req_acc      = req_tvalid && req_tready;

   // ---------------- clearing sweep ----------------
   logic                   clearing_ff, clearing_in;
   logic [CONN_ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic                   clr_last;

   assign clr_last = (clr_cnt_ff == CONN_ADDR_W'(NUM_CONNS - 1));

   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_last) begin
            clearing_in = 1'b0;
         end
      end
   end

   // ---------------- update stage ----------------
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_cmd_ff;
   logic [CONN_W-1:0]      s1_conn_ff;
   logic [CONN_ADDR_W-1:0] s1_addr_ff;
   logic                   s1_range_ff;
   logic [BYTE_W-1:0]      s1_byte_ff;
   logic                   s1_fwd_hit_ff;
   entry_type              s1_fwd_ff;
   logic                   s1_go;

   logic [ENTRY_W-1:0]     ram_rd_data;
   logic                   ram_wr_en;
   logic [CONN_ADDR_W-1:0] ram_wr_addr;
   logic [ENTRY_W-1:0]     ram_wr_data;

   entry_type              cur_entry;
   entry_type              nxt_entry;
   res_type                res;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff;
   logic [CONN_W-1:0]      rsp_conn_ff;
   logic [BYTE_W-1:0]      rsp_byte_ff;
   logic                   rsp_last_ff;

   // advance the update stage when the result register is free or draining
   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clearing_ff && (!s1_valid_ff || s1_go);

   // take the word just written when the previous request hit the same entry
   assign cur_entry = s1_fwd_hit_ff ? s1_fwd_ff : entry_type'(ram_rd_data);

   lpd_update u_update (
      .cmd       (s1_cmd_ff),
      .data_byte (s1_byte_ff),
      .cur       (cur_entry),
      .max_len   (max_len_ff),
      .nxt       (nxt_entry),
      .res       (res)
   );

   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_go && s1_range_ff;
         ram_wr_addr = s1_addr_ff;
         ram_wr_data = nxt_entry;
      end
   end

   lpd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_CONNS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_acc),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = res.valid && s1_range_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: load the update stage on a new request, the result on advance
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_cmd_ff     <= req_tuser;
         s1_conn_ff    <= req_conn;
         s1_addr_ff    <= req_addr;
         s1_range_ff   <= (req_conn_ext < CONN_EXT_W'(NUM_CONNS));
         s1_byte_ff    <= req_byte;
         s1_fwd_hit_ff <= s1_go && s1_range_ff && (s1_addr_ff == req_addr);
         s1_fwd_ff     <= nxt_entry;
      end
      if (s1_go) begin
         rsp_kind_ff <= res.kind;
         rsp_conn_ff <= s1_conn_ff;
         rsp_byte_ff <= (res.kind == KIND_BODY) ? s1_byte_ff : '0;
         rsp_last_ff <= res.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_byte_ff, rsp_conn_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- assertions ----------------
   `LPD_ASSERT_NOW(a_no_req_while_clearing, clock, reset,
      clearing_ff, !req_tready, "request taken during clearing sweep")
   `LPD_ASSERT_NOW(a_stall_only_on_full_rsp, clock, reset,
      s1_valid_ff && !s1_go, rsp_valid_ff && !rsp_tready,
      "update stage held without a blocked result")
   `LPD_ASSERT_NEXT(a_forward_on_same_conn, clock, reset,
      req_acc && s1_go && s1_range_ff && (s1_addr_ff == req_addr),
      s1_fwd_hit_ff, "back-to-back request to one connection not forwarded")
   `LPD_ASSERT_NOW(a_sweep_ends_at_top, clock, reset,
      $fell(clearing_ff), $past(clr_last), "clearing sweep ended early")

endmodule
